// ===== hdl/prv_pkg.sv =====
// ----------------------------------------------------------------------------
// prv_pkg
// Shared types and constants for the pairwise repulsion velocity block.
// ----------------------------------------------------------------------------
package prv_pkg;

  localparam int unsigned RestW  = 21;
  localparam int unsigned AbsW   = 25;
  localparam int unsigned D2W    = 42;
  localparam int unsigned VelW   = 32;
  localparam int unsigned TallyW = 7;
  localparam int unsigned CfgW   = 16;

  localparam logic [15:0] RestScaleReset = 16'd4096;
  localparam logic [15:0] StrengthReset  = 16'd2560;

  typedef enum logic [0:0] {
    REG_REST_SCALE = 1'b0,
    REG_STRENGTH   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [RestW-1:0] rest;
    logic [AbsW-1:0]  adx;
    logic [AbsW-1:0]  ady;
    logic             xneg;
    logic             yneg;
    logic [D2W-1:0]   d2;
    logic             skip;
    logic             has;
    logic             last;
  } prv_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } prv_qstat_t;

endpackage

// ===== hdl/pairwise_repulsion_velocity_top.sv =====
// ----------------------------------------------------------------------------
// pairwise_repulsion_velocity_top
// Soft-sphere pairwise repulsion: sums the velocity of one cell over its run.
// ----------------------------------------------------------------------------
// An overlapping pair goes through the bit-serial square root (29 steps) and three
// divider passes (57 steps each); a skipped or empty item goes straight to the finish.
// The sequencer works on one item at a time, while the front takes an item each cycle
// until its four-entry queue fills.
// Reset clears accumulators, queue and output valid; registers load their defaults.
module pairwise_repulsion_velocity_top import prv_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // own_x, own_y, own_radius, nbr_x, nbr_y, nbr_radius
  input  logic [127:0] s_axis_tdata,
  // has_neighbor
  input  logic [0:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vel_x, vel_y, contact_count, last_rest_length, zero fill
  output logic [95:0]  m_axis_tdata
);

  logic [15:0] scale_q, strength_q;
  logic push, pop;
  prv_entry_t wentry, rentry;
  prv_qstat_t qstat;
  logic [VelW-1:0] vx, vy;
  logic [TallyW-1:0] cnt;
  logic [RestW-1:0] rest;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= RestScaleReset;
      strength_q <= StrengthReset;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_REST_SCALE: scale_q <= cfg_data_i;
        REG_STRENGTH:   strength_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  prv_front u_front (
    .clk_i, .rst_ni,
    .rest_scale_i (scale_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .own_x_i      (s_axis_tdata[23:0]),
    .own_y_i      (s_axis_tdata[47:24]),
    .own_radius_i (s_axis_tdata[63:48]),
    .nbr_x_i      (s_axis_tdata[87:64]),
    .nbr_y_i      (s_axis_tdata[111:88]),
    .nbr_radius_i (s_axis_tdata[127:112]),
    .has_i        (s_axis_tuser[0]),
    .last_i       (s_axis_tlast),
    .q_full_i     (qstat.full),
    .push_o       (push),
    .entry_o      (wentry)
  );

  prv_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .stat_o  (qstat)
  );

  prv_back #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_back (
    .clk_i, .rst_ni,
    .strength_i  (strength_q),
    .entry_i     (rentry),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .vel_x_o     (vx),
    .vel_y_o     (vy),
    .count_o     (cnt),
    .rest_o      (rest)
  );

  assign m_axis_tdata = {4'd0, rest, cnt, vy, vx};

endmodule

// ===== hdl/prv_front.sv =====
// ----------------------------------------------------------------------------
// prv_front
// Input pipeline: rest length, offsets, squared distance and skip decision.
// ----------------------------------------------------------------------------
module prv_front import prv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       rest_scale_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [23:0]       own_x_i,
  input  logic [23:0]       own_y_i,
  input  logic [15:0]       own_radius_i,
  input  logic [23:0]       nbr_x_i,
  input  logic [23:0]       nbr_y_i,
  input  logic [15:0]       nbr_radius_i,
  input  logic              has_i,
  input  logic              last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output prv_entry_t        entry_o
);

  logic en;
  logic v1_q, v2_q, v3_q;
  logic signed [24:0] dx1_q, dy1_q;
  logic [16:0] rsum1_q;
  logic has1_q, last1_q, has2_q, last2_q, has3_q, last3_q;
  logic [RestW-1:0] rest2_q, rest3_q;
  logic [AbsW-1:0] adx2_q, ady2_q, adx3_q, ady3_q;
  logic xneg2_q, yneg2_q, xneg3_q, yneg3_q;
  logic [49:0] sqx3_q, sqy3_q;
  logic [41:0] rr3_q;
  logic [32:0] rprod;
  logic [50:0] d2;

  assign en = !(v3_q && q_full_i);
  assign in_ready_o = en;
  assign rprod = rsum1_q * rest_scale_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q   <= {nbr_x_i[23], nbr_x_i} - {own_x_i[23], own_x_i};
      dy1_q   <= {nbr_y_i[23], nbr_y_i} - {own_y_i[23], own_y_i};
      rsum1_q <= {1'b0, own_radius_i} + {1'b0, nbr_radius_i};
      has1_q  <= has_i;
      last1_q <= last_i;
      rest2_q <= rprod[32:12];
      adx2_q  <= dx1_q[24] ? 25'(-dx1_q) : 25'(dx1_q);
      ady2_q  <= dy1_q[24] ? 25'(-dy1_q) : 25'(dy1_q);
      xneg2_q <= dx1_q[24];
      yneg2_q <= dy1_q[24];
      has2_q  <= has1_q;
      last2_q <= last1_q;
      sqx3_q  <= adx2_q * adx2_q;
      sqy3_q  <= ady2_q * ady2_q;
      rr3_q   <= rest2_q * rest2_q;
      rest3_q <= rest2_q;
      adx3_q  <= adx2_q;
      ady3_q  <= ady2_q;
      xneg3_q <= xneg2_q;
      yneg3_q <= yneg2_q;
      has3_q  <= has2_q;
      last3_q <= last2_q;
    end
  end

  assign d2 = {1'b0, sqx3_q} + {1'b0, sqy3_q};
  assign push_o = v3_q && !q_full_i;

  always_comb begin
    entry_o.rest = rest3_q;
    entry_o.adx  = adx3_q;
    entry_o.ady  = ady3_q;
    entry_o.xneg = xneg3_q;
    entry_o.yneg = yneg3_q;
    entry_o.d2   = d2[D2W-1:0];
    entry_o.skip = (d2 == 51'd0) || (d2 >= {9'd0, rr3_q});
    entry_o.has  = has3_q;
    entry_o.last = last3_q;
  end

endmodule

// ===== hdl/prv_fifo.sv =====
// ----------------------------------------------------------------------------
// prv_fifo
// Four-entry queue between the front pipeline and the force sequencer.
// ----------------------------------------------------------------------------
module prv_fifo import prv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  prv_entry_t wdata_i,
  input  logic       pop_i,
  output prv_entry_t rdata_o,
  output prv_qstat_t stat_o
);

  prv_entry_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o      = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == 3'd4);
  assign stat_o.empty = (cnt_q == 3'd0);

endmodule

// ===== hdl/prv_back.sv =====
// ----------------------------------------------------------------------------
// prv_back
// Force sequencer: iterative square root and divider, accumulation, output.
// ----------------------------------------------------------------------------
module prv_back import prv_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       strength_i,
  input  prv_entry_t        entry_i,
  input  prv_qstat_t        qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VelW-1:0]   vel_x_o,
  output logic [VelW-1:0]   vel_y_o,
  output logic [TallyW-1:0] count_o,
  output logic [RestW-1:0]  rest_o
);

  localparam int unsigned CapRaw = (MAX_NEIGHBORS > 127) ? 127 : MAX_NEIGHBORS;
  localparam logic [TallyW-1:0] Cap = TallyW'(CapRaw);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_SQRT   = 11'b00000000100,
    S_TSET   = 11'b00000001000,
    S_DIV    = 11'b00000010000,
    S_MULT2  = 11'b00000100000,
    S_MULMAG = 11'b00001000000,
    S_MULCX  = 11'b00010000000,
    S_MULCY  = 11'b00100000000,
    S_ACC    = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_T  = 2'd0,
    PH_CX = 2'd1,
    PH_CY = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q;
  prv_entry_t e_q;
  logic [57:0] nsh_q;
  logic [56:0] num_q;
  logic [30:0] rem_q;
  logic [28:0] root_q, d_q, div_q;
  logic [23:0] quo_q, mag_q, cx_q, cy_q;
  logic [15:0] t_q, t2_q;
  logic [5:0] cnt_q;
  logic signed [VelW-1:0] accx_q, accy_q;
  logic [TallyW-1:0] tally_q;
  logic [RestW-1:0] recent_q;
  logic ov_q;

  logic [30:0] srem, stest, drem;
  logic sge, dge;
  logic [28:0] rest16;
  logic [31:0] p16;
  logic [48:0] pcx;
  logic [48:0] pcy;
  logic signed [VelW:0] sx, sy;
  logic emit;

  assign srem  = {rem_q[28:0], nsh_q[57:56]};
  assign stest = {root_q, 2'b01};
  assign sge   = (srem >= stest);
  assign drem  = {rem_q[29:0], num_q[56]};
  assign dge   = (drem >= {2'b00, div_q});
  assign rest16 = {e_q.rest, 8'd0};
  assign pcx = mag_q * e_q.adx;
  assign pcy = mag_q * e_q.ady;
  assign p16 = (state_q == S_MULT2) ? t_q * t_q : strength_i * t2_q;
  assign sx = {accx_q[VelW-1], accx_q}
            + (e_q.xneg ? $signed({9'd0, cx_q}) : -$signed({9'd0, cx_q}));
  assign sy = {accy_q[VelW-1], accy_q}
            + (e_q.yneg ? $signed({9'd0, cy_q}) : -$signed({9'd0, cy_q}));
  assign emit = (state_q == S_FIN) && e_q.last && (!ov_q || out_ready_i);
  assign pop_o = (state_q == S_IDLE) && !qstat_i.empty;

  function automatic logic [VelW-1:0] sat(input logic signed [VelW:0] s);
    logic [VelW-1:0] r;
    if (s[VelW] != s[VelW-1]) r = s[VelW] ? {1'b1, {(VelW-1){1'b0}}} : {1'b0, {(VelW-1){1'b1}}};
    else r = s[VelW-1:0];
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (!qstat_i.empty) state_d = S_CHECK;
      S_CHECK:  state_d = (e_q.has && !e_q.skip) ? S_SQRT : S_FIN;
      S_SQRT:   if (cnt_q == 6'd0) state_d = S_TSET;
      S_TSET:   state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          unique case (ph_q)
            PH_T:    state_d = S_MULT2;
            PH_CX:   state_d = S_MULCY;
            PH_CY:   state_d = S_ACC;
            default: state_d = S_ACC;
          endcase
        end
      end
      S_MULT2:  state_d = S_MULMAG;
      S_MULMAG: state_d = S_MULCX;
      S_MULCX:  state_d = S_DIV;
      S_MULCY:  state_d = S_DIV;
      S_ACC:    state_d = S_FIN;
      S_FIN:    if (!e_q.last || emit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      accx_q   <= '0;
      accy_q   <= '0;
      tally_q  <= '0;
      recent_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (state_q == S_CHECK && e_q.has) recent_q <= e_q.rest;
      if (state_q == S_ACC) begin
        accx_q <= sat(sx);
        accy_q <= sat(sy);
        if (tally_q < Cap) tally_q <= tally_q + 7'd1;
      end
      if (emit) begin
        accx_q   <= '0;
        accy_q   <= '0;
        tally_q  <= '0;
        recent_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) e_q <= entry_i;
    if (emit) begin
      vel_x_o <= accx_q;
      vel_y_o <= accy_q;
      count_o <= tally_q;
      rest_o  <= recent_q;
    end
    unique case (state_q)
      S_CHECK: begin
        nsh_q  <= {e_q.d2, 16'd0};
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= 6'd28;
      end
      S_SQRT: begin
        nsh_q  <= {nsh_q[55:0], 2'b00};
        rem_q  <= sge ? srem - stest : srem;
        root_q <= {root_q[27:0], sge};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) d_q <= {root_q[27:0], sge};
      end
      S_TSET: begin
        num_q <= {12'd0, rest16 - d_q, 16'd0};
        div_q <= rest16;
        rem_q <= '0;
        cnt_q <= 6'd56;
        ph_q  <= PH_T;
      end
      S_DIV: begin
        num_q <= {num_q[55:0], 1'b0};
        rem_q <= dge ? drem - {2'b00, div_q} : drem;
        quo_q <= {quo_q[22:0], dge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (ph_q == PH_T) t_q <= {quo_q[14:0], dge};
          if (ph_q == PH_CX) cx_q <= {quo_q[22:0], dge};
          if (ph_q == PH_CY) cy_q <= {quo_q[22:0], dge};
        end
      end
      S_MULT2:  t2_q <= p16[31:16];
      S_MULMAG: mag_q <= p16[31:8];
      S_MULCX: begin
        num_q <= {pcx, 8'd0};
        div_q <= d_q;
        rem_q <= '0;
        cnt_q <= 6'd56;
        ph_q  <= PH_CX;
      end
      S_MULCY: begin
        num_q <= {pcy, 8'd0};
        div_q <= d_q;
        rem_q <= '0;
        cnt_q <= 6'd56;
        ph_q  <= PH_CY;
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;

  a_tally_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q <= Cap) else $error("contact tally above its cap");
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (accx_q == '0 && accy_q == '0 && tally_q == '0 && recent_q == '0))
    else $error("accumulators not cleared after a result");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ov_q) else $error("result register not marked valid");

endmodule
